@@ src/laplacian_pyramid_codec_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LAPLACIAN_PYRAMID_CODEC_DEFINES_SVH
`define LAPLACIAN_PYRAMID_CODEC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The consequent must hold after the antecedent, with a delay.
`define LPC_ASSERT_LAT2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("assertion failed");

`endif

@@ src/lpc_pkg.sv @@
package lpc_pkg;

	localparam int DIM_BITS     = 9;
	localparam int CRD_BITS     = 11;
	localparam int CNT_BITS     = 18;
	localparam int ACC_GROWTH   = 10;
	localparam int VAL_BITS     = 16;
	localparam int IDX_BITS     = 16;
	localparam int LVL_BITS     = 2;
	localparam int CFG_IDX_BITS = 2;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS = 16;

	typedef enum logic [1:0] {
		LVL_FULL,
		LVL_HALF,
		LVL_QUART
	} level_t;

	typedef enum logic [1:0] {
		CFG_MODE,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic clr;
		logic neg;
		logic div256;
	} mac_ctl_t;

	function automatic logic [2:0] tap_w(input logic [2:0] k);
		logic [2:0] w;
		unique case (k)
			3'd0: w = 3'd1;
			3'd1: w = 3'd4;
			3'd2: w = 3'd6;
			3'd3: w = 3'd4;
			3'd4: w = 3'd1;
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	// Raise to four, lower to the maximum, then round down to a multiple of four.
	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
			input logic [DIM_BITS-1:0] mx);
		logic [DIM_BITS-1:0] x;
		x = v;
		if (x < DIM_BITS'(4)) x = DIM_BITS'(4);
		if (x > mx) x = mx;
		return {x[DIM_BITS-1:2], 2'b00};
	endfunction

endpackage

@@ src/lpc_if.sv @@
interface lpc_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic [lpc_pkg::LVL_BITS-1:0]        level;
	logic [lpc_pkg::IDX_BITS-1:0]        pixel_index;
	logic signed [lpc_pkg::VAL_BITS-1:0] pixel_value;
	logic                                go;

	modport source (output valid, req_type, level, pixel_index, pixel_value, go, input ready);
	modport sink (input valid, req_type, level, pixel_index, pixel_value, go, output ready);
endinterface

interface lpc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [lpc_pkg::LVL_BITS-1:0]        out_level;
	logic [lpc_pkg::IDX_BITS-1:0]        out_index;
	logic signed [lpc_pkg::VAL_BITS-1:0] out_value;

	modport source (output valid, out_level, out_index, out_value, input ready);
	modport sink (input valid, out_level, out_index, out_value, output ready);
endinterface

interface lpc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lpc_pkg::CFG_IDX_BITS-1:0] index;
	logic [lpc_pkg::DIM_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/lpc_ram.sv @@
module lpc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/lpc_mac.sv @@
module lpc_mac #(
	parameter int PIXEL_BITS = lpc_pkg::DEF_PIXEL_BITS,
	localparam int ACC_W = PIXEL_BITS + lpc_pkg::ACC_GROWTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpc_pkg::mac_ctl_t            ctl,
	input  logic signed [PIXEL_BITS-1:0] data,
	input  logic [6:0]                   weight,
	output logic signed [ACC_W-1:0]      quot
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] rnd;

	assign prod = data * $signed({1'b0, weight});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= ctl.neg ? acc_q - prod : acc_q + prod;
		end
	end

	// Round to nearest with ties upward: add half the divisor, then floor.
	assign rnd  = acc_q + (ctl.div256 ? ACC_W'(128) : ACC_W'(32));
	assign quot = ctl.div256 ? (rnd >>> 8) : (rnd >>> 6);

endmodule

@@ src/laplacian_pyramid_codec.sv @@
// A write is stored when taken; a read result passes the store read and output registers.
// After a write with go, each output pixel has a tap, centre, drain and write phase;
// decompose W*H/4 + W*H/16 + W*H + W*H/4 pixels, reconstruct W*H/4 + W*H. A muxed store
// read port feeds one shared multiply-accumulate unit, one tap per tap-phase cycle.
// Reset sets mode 0 and a 256 by 256 frame (clamped); the stores are not cleared.
module laplacian_pyramid_codec #(
	parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = lpc_pkg::DEF_PIXEL_BITS
) (
	input logic       clk,
	input logic       arst_n,
	lpc_req_if.sink   req,
	lpc_rsp_if.source rsp,
	lpc_cfg_if.sink   cfg
);

	localparam int DB    = lpc_pkg::DIM_BITS;
	localparam int CB    = lpc_pkg::CRD_BITS;
	localparam int NB    = lpc_pkg::CNT_BITS;
	localparam int VB    = lpc_pkg::VAL_BITS;
	localparam int ACC_W = PIXEL_BITS + lpc_pkg::ACC_GROWTH;
	localparam int D0    = MAX_WIDTH * MAX_HEIGHT;
	localparam int D1    = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
	localparam int D2    = (MAX_WIDTH / 4) * (MAX_HEIGHT / 4);
	localparam int AW0   = (D0 > 1) ? $clog2(D0) : 1;
	localparam int AW1   = (D1 > 1) ? $clog2(D1) : 1;
	localparam int AW2   = (D2 > 1) ? $clog2(D2) : 1;
	localparam int WMAX_I = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int HMAX_I = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
	localparam logic [DB-1:0] WMAX  = DB'(WMAX_I);
	localparam logic [DB-1:0] HMAX  = DB'(HMAX_I);
	localparam logic [DB-1:0] RST_W = DB'(((WMAX_I < 256) ? WMAX_I : 256) / 4 * 4);
	localparam logic [DB-1:0] RST_H = DB'(((HMAX_I < 256) ? HMAX_I : 256) / 4 * 4);
	localparam logic signed [ACC_W-1:0] PX_MAX =
		ACC_W'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] PX_MIN = -PX_MAX - ACC_W'(1);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_PASS} state_t;
	typedef enum logic [2:0] {P_DOWN1, P_DOWN2, P_RES0, P_RES1, P_REC1, P_REC0} pass_t;
	typedef enum logic [1:0] {PH_TAP, PH_CTR, PH_DRAIN, PH_WRITE} phase_t;
	typedef enum logic [1:0] {ST_FULL, ST_HALF, ST_QUART, ST_SCR} store_t;

	function automatic logic signed [PIXEL_BITS-1:0] sat_px(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > PX_MAX) r = PX_MAX;
		if (v < PX_MIN) r = PX_MIN;
		return PIXEL_BITS'(r);
	endfunction

	state_t          state_q;
	pass_t           pass_q;
	phase_t          phase_q;
	logic [2:0]      ky_q, kx_q;
	logic [DB-1:0]   oy_q, ox_q;
	logic            mode_q;
	logic [DB-1:0]   fw_q, fh_q;
	logic            out_valid_q;
	logic [lpc_pkg::LVL_BITS-1:0] out_level_q;
	logic [lpc_pkg::IDX_BITS-1:0] out_index_q;
	logic signed [VB-1:0] out_value_q;

	logic            en_s1, neg_s1, rok_s1;
	logic [6:0]      weight_s1;
	store_t          rsel_s1;

	logic [DB-1:0]   w1, w2, w3, h1, h2, h3;
	logic [NB-1:0]   cnt0, cnt1, cnt2, idx_ext;
	logic            req_acc, lvl_ok, ld_we, pass_we;
	logic [DB-1:0]   out_w, out_h, src_w, src_h;
	logic            is_up, has_ctr, neg;
	store_t          src_st, ctr_st, dst_st, lvl_st, rd_sel;
	logic [CB-1:0]   base_y, base_x, sy, sx, ry, rx;
	logic            ok_y, ok_x, ctr_sel, tap_rd, ctr_rd;
	logic [DB-1:0]   mul_a, mul_b, mul_c;
	logic [NB-1:0]   prod, lin_addr, rd_addr, wr_addr;
	logic [5:0]      wprod;
	logic [6:0]      weight;
	logic signed [PIXEL_BITS-1:0] rd0, rd1, rd2, rd3, rdata, wdata;
	logic signed [ACC_W-1:0] quot;
	lpc_pkg::mac_ctl_t mac_ctl;
	logic            we0, we1, we2, we3;

	assign w1 = fw_q;
	assign w2 = fw_q >> 1;
	assign w3 = fw_q >> 2;
	assign h1 = fh_q;
	assign h2 = fh_q >> 1;
	assign h3 = fh_q >> 2;
	assign cnt0 = w1 * h1;
	assign cnt1 = w2 * h2;
	assign cnt2 = w3 * h3;
	assign idx_ext = NB'(req.pixel_index);

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		lvl_ok = 1'b0;
		lvl_st = ST_FULL;
		unique case (req.level)
			lpc_pkg::LVL_FULL: begin
				lvl_ok = idx_ext < cnt0;
				lvl_st = ST_FULL;
			end
			lpc_pkg::LVL_HALF: begin
				lvl_ok = idx_ext < cnt1;
				lvl_st = ST_HALF;
			end
			lpc_pkg::LVL_QUART: begin
				lvl_ok = idx_ext < cnt2;
				lvl_st = ST_QUART;
			end
			default: begin
				lvl_ok = 1'b0;
				lvl_st = ST_FULL;
			end
		endcase
	end

	always_comb begin
		out_w = w2; out_h = h2; src_w = w1; src_h = h1;
		is_up = 1'b0; has_ctr = 1'b0; neg = 1'b0;
		src_st = ST_FULL; ctr_st = ST_FULL; dst_st = ST_HALF;
		unique case (pass_q)
			P_DOWN1: begin
				out_w = w2; out_h = h2; src_w = w1; src_h = h1;
				src_st = ST_FULL; dst_st = ST_HALF;
			end
			P_DOWN2: begin
				out_w = w3; out_h = h3; src_w = w2; src_h = h2;
				src_st = ST_HALF; dst_st = ST_QUART;
			end
			P_RES0: begin
				out_w = w1; out_h = h1; src_w = w2; src_h = h2;
				is_up = 1'b1; has_ctr = 1'b1; neg = 1'b1;
				src_st = ST_HALF; ctr_st = ST_FULL; dst_st = ST_FULL;
			end
			P_RES1: begin
				out_w = w2; out_h = h2; src_w = w3; src_h = h3;
				is_up = 1'b1; has_ctr = 1'b1; neg = 1'b1;
				src_st = ST_QUART; ctr_st = ST_HALF; dst_st = ST_HALF;
			end
			P_REC1: begin
				out_w = w2; out_h = h2; src_w = w3; src_h = h3;
				is_up = 1'b1; has_ctr = 1'b1;
				src_st = ST_QUART; ctr_st = ST_HALF; dst_st = ST_SCR;
			end
			P_REC0: begin
				out_w = w1; out_h = h1; src_w = w2; src_h = h2;
				is_up = 1'b1; has_ctr = 1'b1;
				src_st = ST_SCR; ctr_st = ST_FULL; dst_st = ST_FULL;
			end
			default: begin
				out_w = w2; out_h = h2; src_w = w1; src_h = h1;
			end
		endcase
	end

	// Tap position: the blur samples at twice the output coordinate, the upsample
	// reads only even positions of the stuffed grid and halves them.
	assign base_y = is_up ? CB'(oy_q) : CB'({oy_q, 1'b0});
	assign base_x = is_up ? CB'(ox_q) : CB'({ox_q, 1'b0});
	assign sy = base_y + CB'(ky_q) - CB'(2);
	assign sx = base_x + CB'(kx_q) - CB'(2);
	assign ry = is_up ? {sy[CB-1], sy[CB-1:1]} : sy;
	assign rx = is_up ? {sx[CB-1], sx[CB-1:1]} : sx;
	assign ok_y = !ry[CB-1] && (ry < CB'(src_h)) && (!is_up || !sy[0]);
	assign ok_x = !rx[CB-1] && (rx < CB'(src_w)) && (!is_up || !sx[0]);

	assign ctr_sel = (phase_q == PH_CTR) || (phase_q == PH_WRITE);
	assign mul_a = ctr_sel ? oy_q : ry[DB-1:0];
	assign mul_b = ctr_sel ? out_w : src_w;
	assign mul_c = ctr_sel ? ox_q : rx[DB-1:0];
	assign prod = mul_a * mul_b;
	assign lin_addr = prod + NB'(mul_c);

	assign tap_rd = (state_q == S_PASS) && (phase_q == PH_TAP) && ok_y && ok_x;
	assign ctr_rd = (state_q == S_PASS) && (phase_q == PH_CTR) && has_ctr;
	assign wprod  = lpc_pkg::tap_w(ky_q) * lpc_pkg::tap_w(kx_q);
	assign weight = ctr_rd ? 7'd64 : {1'b0, wprod};

	assign rd_addr = (state_q == S_IDLE) ? idx_ext : lin_addr;
	assign rd_sel  = (state_q == S_IDLE) ? lvl_st : (ctr_sel ? ctr_st : src_st);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1     <= 1'b0;
			neg_s1    <= 1'b0;
			rok_s1    <= 1'b0;
			weight_s1 <= '0;
			rsel_s1   <= ST_FULL;
		end else begin
			en_s1     <= tap_rd || ctr_rd;
			neg_s1    <= neg && tap_rd;
			rok_s1    <= lvl_ok;
			weight_s1 <= weight;
			rsel_s1   <= rd_sel;
		end
	end

	always_comb begin
		unique case (rsel_s1)
			ST_FULL:  rdata = rd0;
			ST_HALF:  rdata = rd1;
			ST_QUART: rdata = rd2;
			ST_SCR:   rdata = rd3;
			default:  rdata = rd0;
		endcase
	end

	assign mac_ctl.en     = en_s1;
	assign mac_ctl.clr    = pass_we;
	assign mac_ctl.neg    = neg_s1;
	assign mac_ctl.div256 = !is_up;

	lpc_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.data   (rdata),
		.weight (weight_s1),
		.quot   (quot)
	);

	assign ld_we   = req_acc && !req.req_type;
	assign pass_we = (state_q == S_PASS) && (phase_q == PH_WRITE);
	assign wr_addr = ld_we ? idx_ext : lin_addr;
	assign wdata   = ld_we ? sat_px(ACC_W'(req.pixel_value)) : sat_px(quot);

	assign we0 = (ld_we && lvl_ok && lvl_st == ST_FULL) || (pass_we && dst_st == ST_FULL);
	assign we1 = (ld_we && lvl_ok && lvl_st == ST_HALF) || (pass_we && dst_st == ST_HALF);
	assign we2 = (ld_we && lvl_ok && lvl_st == ST_QUART) || (pass_we && dst_st == ST_QUART);
	assign we3 = pass_we && dst_st == ST_SCR;

	lpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(D0)) u_full (
		.clk (clk), .we (we0), .waddr (AW0'(wr_addr)), .wdata (wdata),
		.raddr (AW0'(rd_addr)), .rdata (rd0)
	);

	lpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(D1)) u_half (
		.clk (clk), .we (we1), .waddr (AW1'(wr_addr)), .wdata (wdata),
		.raddr (AW1'(rd_addr)), .rdata (rd1)
	);

	lpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(D2)) u_quart (
		.clk (clk), .we (we2), .waddr (AW2'(wr_addr)), .wdata (wdata),
		.raddr (AW2'(rd_addr)), .rdata (rd2)
	);

	lpc_ram #(.WIDTH(PIXEL_BITS), .DEPTH(D1)) u_scr (
		.clk (clk), .we (we3), .waddr (AW1'(wr_addr)), .wdata (wdata),
		.raddr (AW1'(rd_addr)), .rdata (rd3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= P_DOWN1;
			phase_q     <= PH_TAP;
			ky_q        <= '0;
			kx_q        <= '0;
			oy_q        <= '0;
			ox_q        <= '0;
			mode_q      <= 1'b0;
			fw_q        <= RST_W;
			fh_q        <= RST_H;
			out_valid_q <= 1'b0;
			out_level_q <= '0;
			out_index_q <= '0;
			out_value_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					lpc_pkg::CFG_MODE:   mode_q <= cfg.data[0];
					lpc_pkg::CFG_WIDTH:  fw_q <= lpc_pkg::clamp_dim(cfg.data, WMAX);
					lpc_pkg::CFG_HEIGHT: fh_q <= lpc_pkg::clamp_dim(cfg.data, HMAX);
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.req_type) begin
							out_level_q <= req.level;
							out_index_q <= req.pixel_index;
							state_q     <= S_READ;
						end else if (req.go) begin
							state_q <= S_PASS;
							pass_q  <= mode_q ? P_REC1 : P_DOWN1;
							phase_q <= PH_TAP;
							ky_q    <= '0;
							kx_q    <= '0;
							oy_q    <= '0;
							ox_q    <= '0;
						end
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					out_value_q <= rok_s1 ? VB'(rdata) : '0;
					state_q     <= S_IDLE;
				end
				S_PASS: begin
					unique case (phase_q)
						PH_TAP: begin
							if (kx_q == 3'd4) begin
								kx_q <= '0;
								if (ky_q == 3'd4) begin
									ky_q    <= '0;
									phase_q <= PH_CTR;
								end else begin
									ky_q <= ky_q + 3'd1;
								end
							end else begin
								kx_q <= kx_q + 3'd1;
							end
						end
						PH_CTR:   phase_q <= PH_DRAIN;
						PH_DRAIN: phase_q <= PH_WRITE;
						PH_WRITE: begin
							phase_q <= PH_TAP;
							if (ox_q == out_w - DB'(1)) begin
								ox_q <= '0;
								if (oy_q == out_h - DB'(1)) begin
									oy_q <= '0;
									unique case (pass_q)
										P_DOWN1: pass_q <= P_DOWN2;
										P_DOWN2: pass_q <= P_RES0;
										P_RES0:  pass_q <= P_RES1;
										P_REC1:  pass_q <= P_REC0;
										default: state_q <= S_IDLE;
									endcase
								end else begin
									oy_q <= oy_q + DB'(1);
								end
							end else begin
								ox_q <= ox_q + DB'(1);
							end
						end
						default: phase_q <= PH_TAP;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_level = out_level_q;
	assign rsp.out_index = out_index_q;
	assign rsp.out_value = out_value_q;

endmodule

@@ src/lpc_checker.sv @@
`include "laplacian_pyramid_codec_defines.svh"

module lpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                req_type,
	input logic [lpc_pkg::LVL_BITS-1:0]        req_level,
	input logic [lpc_pkg::IDX_BITS-1:0]        req_pixel_index,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [lpc_pkg::LVL_BITS-1:0]        rsp_out_level,
	input logic [lpc_pkg::IDX_BITS-1:0]        rsp_out_index
);

	logic rd_xfer;

	assign rd_xfer = req_valid && req_ready && req_type;

	// A pending result is held until its transfer completes.
	`LPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// No request is taken while a result waits.
	`LPC_ASSERT_SAME(a_no_req_while_rsp, rsp_valid, !req_ready)

	// A read transfer leads to a result that echoes the address.
	`LPC_ASSERT_LAT2(a_read_echo, rd_xfer, rsp_valid && (rsp_out_index == $past(req_pixel_index, 2)) && (rsp_out_level == $past(req_level, 2)))

	// A write transfer never produces a result.
	`LPC_ASSERT_NEXT(a_write_silent, req_valid && req_ready && !req_type, !rsp_valid)

endmodule

bind laplacian_pyramid_codec lpc_checker u_lpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_type        (req.req_type),
	.req_level       (req.level),
	.req_pixel_index (req.pixel_index),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_out_level   (rsp.out_level),
	.rsp_out_index   (rsp.out_index)
);
